// ===== rtl/grm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types, constants and the quarter-wave sine table of the grid ray
// marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

  // default parameter values
  localparam int unsigned DEF_SCREEN_COLUMNS = 120;
  localparam int unsigned DEF_SCREEN_ROWS    = 40;
  localparam int unsigned DEF_MAP_SIZE       = 16;
  localparam int unsigned DEF_MAX_STEPS      = 160;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALLS_0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALLS_1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALLS_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WALLS_3   = 3'd6;
  localparam int unsigned CFG_DATA_W = 64;

  // stop kinds
  localparam logic [1:0] STOP_WALL     = 2'd0;
  localparam logic [1:0] STOP_LEFT_MAP = 2'd1;
  localparam logic [1:0] STOP_DEPTH    = 2'd2;

  // field widths
  localparam int unsigned POS_W   = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SIN_W   = 16;
  localparam int unsigned COL_W   = 7;

  // angle constants
  localparam int unsigned FOV_SHIFT    = 13;
  localparam int unsigned FOV_UNITS    = 1 << FOV_SHIFT;
  localparam int unsigned QUARTER_TURN = 16384;
  localparam int unsigned SINE_ONE     = 16384;

  // march geometry: one map unit is 4096 position lsbs times 40 (0.1 unit steps)
  localparam int unsigned CELL_SCALE = 40;
  localparam int unsigned CELL_SPAN  = 163840;
  localparam int unsigned REM_W      = 18;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned WALL_DIM   = 16;
  localparam int unsigned WALL_BITS  = WALL_DIM * WALL_DIM;

  // ceiling: (rows*steps - 20*rows) / (2*steps)
  localparam int unsigned CEIL_BIAS_STEPS = 20;

  // shared divider widths, sized for the full parameter ranges
  localparam int unsigned DIV_NUM_W = 21;
  localparam int unsigned DIV_DEN_W = 12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFS_DIV,
    S_SIN_X,
    S_SIN_Y,
    S_LOAD,
    S_FIRST,
    S_MARCH,
    S_CEIL_PREP,
    S_CEIL_START,
    S_CEIL_DIV,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic advance;
  } step_ctrl_t;

  typedef struct packed {
    logic off_map;
    logic wall;
  } march_stat_t;

  // Q1.14 samples of sin(k*pi/128), k = 0 .. 64
  function automatic logic [14:0] quarter_sine(input logic [6:0] idx);
    logic [14:0] v;
    case (idx)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd402;   7'd2:  v = 15'd804;
      7'd3:  v = 15'd1205;  7'd4:  v = 15'd1606;  7'd5:  v = 15'd2006;
      7'd6:  v = 15'd2404;  7'd7:  v = 15'd2801;  7'd8:  v = 15'd3196;
      7'd9:  v = 15'd3590;  7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
      7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
      7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
      7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
      7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
      7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
      7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
      7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
      7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
      7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
      7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
      7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
      7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
      7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/grm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_divider
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grm_divider
  import grm_pkg::*;
#(
  parameter int unsigned NUM_W = DIV_NUM_W,
  parameter int unsigned DEN_W = DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quot_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[NUM_W-2:0], ge};
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/grm_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_sine
// Table sine with linear interpolation, Q1.14 result, registered output.
// ----------------------------------------------------------------------------
module grm_sine
  import grm_pkg::*;
(
  input  logic                    clk_i,
  input  logic [ANGLE_W-1:0]      angle_i,
  output logic signed [SIN_W-1:0] sin_o
);

  logic [1:0]            quad;
  logic [14:0]           phase;
  logic [6:0]            idx;
  logic [7:0]            frac;
  logic [14:0]           lo;
  logic [14:0]           hi;
  logic [8:0]            slope;
  logic [16:0]           prod;
  logic [14:0]           mag;
  logic signed [SIN_W-1:0] sin_d;
  logic signed [SIN_W-1:0] sin_q;

  always_comb begin
    quad  = angle_i[ANGLE_W-1 -: 2];
    // second and fourth quadrants run the quarter wave backwards
    phase = quad[0] ? 15'(QUARTER_TURN) - {1'b0, angle_i[13:0]} : {1'b0, angle_i[13:0]};
    idx   = phase[14:8];
    frac  = phase[7:0];
    lo    = quarter_sine(idx);
    hi    = quarter_sine(idx + 7'd1);
    slope = 9'(hi - lo);
    prod  = 17'(slope) * 17'(frac);
    mag   = idx[6] ? 15'(SINE_ONE) : lo + 15'(prod[16:8]);
    sin_d = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
  end

  assign sin_o = sin_q;

endmodule

// ===== rtl/grm_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_stepper
// Ray position as cell index plus remainder per axis, one step per advance,
// with the map bounds and wall test on the current cell.
// ----------------------------------------------------------------------------
module grm_stepper
  import grm_pkg::*;
#(
  parameter  int unsigned MAP_SIZE  = DEF_MAP_SIZE,
  parameter  int unsigned MAX_STEPS = DEF_MAX_STEPS,
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  step_ctrl_t              ctrl_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  input  logic signed [SIN_W-1:0] step_x_i,
  input  logic signed [SIN_W-1:0] step_y_i,
  input  logic [WALL_BITS-1:0]    wall_map_i,
  output march_stat_t             stat_o,
  output logic [STEP_W-1:0]       step_n_o
);

  localparam int unsigned SUM_W = REM_W + 1;
  localparam logic signed [SUM_W-1:0] SPAN_S = SUM_W'(CELL_SPAN);

  logic signed [CELL_W-1:0] cell_q [2];
  logic signed [CELL_W-1:0] cell_d [2];
  logic [REM_W-1:0]         rem_q  [2];
  logic [REM_W-1:0]         rem_d  [2];
  logic [POS_W-1:0]         pos    [2];
  logic signed [SIN_W-1:0]  delta  [2];
  logic signed [SUM_W-1:0]  sum    [2];
  logic [1:0]               off;
  logic [1:0]               in_wall_map;
  logic [3:0]               wall_idx [2];
  logic [STEP_W-1:0]        n_q, n_d;

  assign pos[0]   = pos_x_i;
  assign pos[1]   = pos_y_i;
  assign delta[0] = step_x_i;
  assign delta[1] = step_y_i;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum[a]    = $signed({1'b0, rem_q[a]}) + SUM_W'(delta[a]);
      cell_d[a] = cell_q[a];
      rem_d[a]  = rem_q[a];
      if (ctrl_i.load) begin
        cell_d[a] = CELL_W'(pos[a][POS_W-1 -: 4]);
        rem_d[a]  = REM_W'(pos[a][11:0] * CELL_SCALE);
      end else if (ctrl_i.advance) begin
        // a step is below one cell span, so at most one carry or borrow
        if (sum[a] < 0) begin
          rem_d[a]  = REM_W'(sum[a] + SPAN_S);
          cell_d[a] = cell_q[a] - CELL_W'(1);
        end else if (sum[a] >= SPAN_S) begin
          rem_d[a]  = REM_W'(sum[a] - SPAN_S);
          cell_d[a] = cell_q[a] + CELL_W'(1);
        end else begin
          rem_d[a]  = REM_W'(sum[a]);
        end
      end
    end
  end

  // floor cell -1 with a nonzero remainder truncates to cell 0
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (cell_q[a][CELL_W-1]) begin
        off[a]         = !((cell_q[a] == '1) && (rem_q[a] != '0));
        in_wall_map[a] = 1'b1;
        wall_idx[a]    = '0;
      end else begin
        off[a]         = cell_q[a][CELL_W-2:0] >= (CELL_W-1)'(MAP_SIZE);
        in_wall_map[a] = cell_q[a][CELL_W-2:0] < (CELL_W-1)'(WALL_DIM);
        wall_idx[a]    = cell_q[a][3:0];
      end
    end
    stat_o.off_map = |off;
    stat_o.wall    = &in_wall_map && wall_map_i[{wall_idx[1], wall_idx[0]}];
  end

  always_comb begin
    n_d = n_q;
    if (ctrl_i.load) begin
      n_d = '0;
    end else if (ctrl_i.advance) begin
      n_d = n_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else begin
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    rem_q  <= rem_d;
  end

  assign step_n_o = n_q;

endmodule

// ===== rtl/grid_ray_march_column.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_march_column
// Casts one screen column ray through a 16x16 wall map in fixed 0.1 unit
// steps and returns the step count, stop kind and ceiling and floor rows.
// ----------------------------------------------------------------------------
// Each item marches n steps (at most MAX_STEPS, one per cycle) between input
// accept and result valid; a new item is accepted only after the last result
// has been loaded into the output register, which must first be free.
// The two passes share the bit-serial divider; a result waits in the
// output register while the next item runs.
// Reset clears the configuration registers, the sequencer and output valid.
// ----------------------------------------------------------------------------
module grid_ray_march_column
  import grm_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int unsigned MAP_SIZE       = DEF_MAP_SIZE,
  parameter int unsigned MAX_STEPS      = DEF_MAX_STEPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COL_W-1:0]      column_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COL_W-1:0]      column_echo_o,
  output logic [7:0]            march_steps_o,
  output logic [1:0]            stop_kind_o,
  output logic signed [9:0]     ceiling_row_o,
  output logic [8:0]            floor_row_o
);

  localparam int unsigned STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int unsigned NUMER_W = DIV_NUM_W + 2;

  state_e state_q, state_d;

  // configuration
  logic [POS_W-1:0]      player_x_q, player_x_d;
  logic [POS_W-1:0]      player_y_q, player_y_d;
  logic [ANGLE_W-1:0]    heading_q, heading_d;
  logic [CFG_DATA_W-1:0] walls_q [4];
  logic [CFG_DATA_W-1:0] walls_d [4];
  logic [WALL_BITS-1:0]  wall_map;

  // control
  logic       div_start;
  logic       div_ceil;
  logic       sine_cos;
  logic       out_free;
  logic       out_load;
  logic       march_stop;
  step_ctrl_t step_ctrl;

  // datapath
  logic [COL_W-1:0]          col_q, col_d;
  logic [ANGLE_W-1:0]        angle_q, angle_d;
  logic signed [SIN_W-1:0]   sx_q, sx_d;
  logic signed [SIN_W-1:0]   sy_q, sy_d;
  logic [STEP_W-1:0]         steps_q, steps_d;
  logic [1:0]                kind_q, kind_d;
  logic [DIV_NUM_W-1:0]      num_q, num_d;
  logic                      neg_q, neg_d;
  logic [9:0]                ceil_q, ceil_d;
  logic [NUMER_W-1:0]        rows_steps;
  logic signed [NUMER_W-1:0] numer;
  logic [NUMER_W-1:0]        numer_mag;

  // shared units
  logic [DIV_NUM_W-1:0]    div_num;
  logic [DIV_DEN_W-1:0]    div_den;
  logic                    div_done;
  logic [DIV_NUM_W-1:0]    div_quot;
  logic [ANGLE_W-1:0]      sine_angle;
  logic signed [SIN_W-1:0] sine_val;
  march_stat_t             stat;
  logic [STEP_W-1:0]       step_n;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [COL_W-1:0] echo_q, echo_d;
  logic [7:0]       steps_out_q, steps_out_d;
  logic [1:0]       kind_out_q, kind_out_d;
  logic [9:0]       ceil_out_q, ceil_out_d;
  logic [8:0]       floor_out_q, floor_out_d;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_comb begin
    player_x_d = player_x_q;
    player_y_d = player_y_q;
    heading_d  = heading_q;
    walls_d    = walls_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PLAYER_X: player_x_d = cfg_data_i[POS_W-1:0];
        REG_PLAYER_Y: player_y_d = cfg_data_i[POS_W-1:0];
        REG_HEADING:  heading_d  = cfg_data_i[ANGLE_W-1:0];
        REG_WALLS_0:  walls_d[0] = cfg_data_i;
        REG_WALLS_1:  walls_d[1] = cfg_data_i;
        REG_WALLS_2:  walls_d[2] = cfg_data_i;
        REG_WALLS_3:  walls_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  // bit row*16 + column
  assign wall_map = {walls_q[3], walls_q[2], walls_q[1], walls_q[0]};

  // ------------------------------------------------------------- sequencer
  assign out_free   = !out_valid_q || out_ready_i;
  assign march_stop = stat.off_map || stat.wall || (step_n == STEP_W'(MAX_STEPS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_valid_i) state_d = S_OFS_DIV;
      S_OFS_DIV:    if (div_done) state_d = S_SIN_X;
      S_SIN_X:      state_d = S_SIN_Y;
      S_SIN_Y:      state_d = S_LOAD;
      S_LOAD:       state_d = S_FIRST;
      S_FIRST:      state_d = S_MARCH;
      S_MARCH:      if (march_stop) state_d = S_CEIL_PREP;
      S_CEIL_PREP:  state_d = S_CEIL_START;
      S_CEIL_START: state_d = S_CEIL_DIV;
      S_CEIL_DIV:   if (div_done) state_d = S_FINISH;
      S_FINISH:     if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    div_start         = 1'b0;
    div_ceil          = 1'b0;
    sine_cos          = 1'b0;
    out_load          = 1'b0;
    step_ctrl.load    = 1'b0;
    step_ctrl.advance = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i;
      end
      S_SIN_Y:      sine_cos = 1'b1;
      S_LOAD:       step_ctrl.load = 1'b1;
      S_FIRST:      step_ctrl.advance = 1'b1;
      S_MARCH:      step_ctrl.advance = !march_stop;
      S_CEIL_START: begin
        div_start = 1'b1;
        div_ceil  = 1'b1;
      end
      S_FINISH:     out_load = out_free;
      default: ;
    endcase
  end

  // -------------------------------------------------------------- datapath
  assign div_num = div_ceil ? num_q : DIV_NUM_W'(column_index_i) << FOV_SHIFT;
  assign div_den = div_ceil ? DIV_DEN_W'({steps_q, 1'b0}) : DIV_DEN_W'(SCREEN_COLUMNS);
  assign sine_angle = angle_q + (sine_cos ? ANGLE_W'(QUARTER_TURN) : '0);

  // signed ceiling numerator rows*steps - 20*rows, divided as a magnitude
  always_comb begin
    rows_steps = NUMER_W'(SCREEN_ROWS) * NUMER_W'(steps_q);
    numer      = $signed(rows_steps - NUMER_W'(CEIL_BIAS_STEPS * SCREEN_ROWS));
    numer_mag  = numer[NUMER_W-1] ? NUMER_W'(-numer) : NUMER_W'(numer);
  end

  always_comb begin
    col_d   = col_q;
    angle_d = angle_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    steps_d = steps_q;
    kind_d  = kind_q;
    num_d   = num_q;
    neg_d   = neg_q;
    ceil_d  = ceil_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) col_d = column_index_i;
      S_OFS_DIV: begin
        if (div_done) begin
          angle_d = heading_q - ANGLE_W'(FOV_UNITS / 2) + div_quot[ANGLE_W-1:0];
        end
      end
      S_SIN_Y:   sx_d = sine_val;
      S_LOAD:    sy_d = sine_val;
      S_MARCH: begin
        if (stat.off_map) begin
          steps_d = STEP_W'(MAX_STEPS);
          kind_d  = STOP_LEFT_MAP;
        end else if (stat.wall) begin
          steps_d = step_n;
          kind_d  = STOP_WALL;
        end else begin
          steps_d = STEP_W'(MAX_STEPS);
          kind_d  = STOP_DEPTH;
        end
      end
      S_CEIL_PREP: begin
        num_d = numer_mag[DIV_NUM_W-1:0];
        neg_d = numer[NUMER_W-1];
      end
      S_CEIL_DIV: begin
        // truncation toward zero: negate the magnitude quotient
        if (div_done) ceil_d = neg_q ? 10'd0 - div_quot[9:0] : div_quot[9:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    echo_d      = echo_q;
    steps_out_d = steps_out_q;
    kind_out_d  = kind_out_q;
    ceil_out_d  = ceil_out_q;
    floor_out_d = floor_out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      echo_d      = col_q;
      steps_out_d = 8'(steps_q);
      kind_out_d  = kind_q;
      ceil_out_d  = ceil_q;
      floor_out_d = 9'(SCREEN_ROWS) - ceil_q[8:0];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      player_x_q  <= '0;
      player_y_q  <= '0;
      heading_q   <= '0;
      walls_q     <= '{default: '0};
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      player_x_q  <= player_x_d;
      player_y_q  <= player_y_d;
      heading_q   <= heading_d;
      walls_q     <= walls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q       <= col_d;
    angle_q     <= angle_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    steps_q     <= steps_d;
    kind_q      <= kind_d;
    num_q       <= num_d;
    neg_q       <= neg_d;
    ceil_q      <= ceil_d;
    echo_q      <= echo_d;
    steps_out_q <= steps_out_d;
    kind_out_q  <= kind_out_d;
    ceil_out_q  <= ceil_out_d;
    floor_out_q <= floor_out_d;
  end

  // --------------------------------------------------------------- units
  grm_divider #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  grm_sine u_sine (
    .clk_i  (clk_i),
    .angle_i(sine_angle),
    .sin_o  (sine_val)
  );

  grm_stepper #(
    .MAP_SIZE (MAP_SIZE),
    .MAX_STEPS(MAX_STEPS)
  ) u_stepper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (step_ctrl),
    .pos_x_i   (player_x_q),
    .pos_y_i   (player_y_q),
    .step_x_i  (sx_q),
    .step_y_i  (sy_q),
    .wall_map_i(wall_map),
    .stat_o    (stat),
    .step_n_o  (step_n)
  );

  assign out_valid_o   = out_valid_q;
  assign column_echo_o = echo_q;
  assign march_steps_o = steps_out_q;
  assign stop_kind_o   = kind_out_q;
  assign ceiling_row_o = $signed(ceil_out_q);
  assign floor_row_o   = floor_out_q;

endmodule
